@@ sv/pal_pkg.sv @@
// Shared types and constants for the positional array list.
// Used by pal_cell and positional_array_list_top; no dependencies.
package pal_pkg;

    // Default list capacity
    localparam int unsigned CAPACITY_DEF = 64;

    // Fixed field widths
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_LAST  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_READ_AT   = 3'd6,
        OP_NONE      = 3'd7
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // a transaction is accepted this cycle
        logic ins;    // open a gap at idx and store the new value
        logic del;    // close the gap at idx
        logic rd;     // capture the slot at idx into the read tap
    } t_cell_ctl;

endpackage

@@ sv/positional_array_list_top.sv @@
// Positional array list: a chain of slot cells with a broadcast command.
// Pipeline: an accepted transaction is registered in the cell chain (decode and
// shift), then the read-tap OR is registered into the output register.
// Throughput: one transaction per cycle while results are taken.
// Reset (synchronous, active low) empties the list; slot contents are kept.
module positional_array_list_top import pal_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [OPCODE_W-1:0]        i_opcode,
    input  logic [CNT_W-1:0]           i_position,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VALUE_W-1:0]  o_read_value,
    output logic [CNT_W-1:0]           o_count
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Control registers
    logic                r_pend;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_count;
    // Payload registers
    logic [STATUS_W-1:0] r_p_status;
    logic [CNT_W-1:0]    r_p_count;
    logic [STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]    r_o_count;
    logic signed [VALUE_W-1:0] r_read_value;

    logic                n_pend;
    logic                n_out_valid;
    logic [CNT_W-1:0]    n_count;

    logic                accept;
    logic                move;
    t_cell_ctl           cell_ctl;
    logic [IDX_W-1:0]    cell_idx;
    t_status             status;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    pos_m1;
    logic                pos_ok;
    logic                full;
    logic                empty;
    logic signed [VALUE_W-1:0] tap_or;

    logic signed [VALUE_W-1:0] slot_q [CAPACITY];
    logic signed [VALUE_W-1:0] tap_q  [CAPACITY];

    // Handshake
    assign move    = r_pend && (!r_out_valid || !i_stall);
    assign o_stall = r_pend && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // Position checks against the current count
    assign pos_ext = CMP_W'(i_position);
    assign cnt_ext = CMP_W'(r_count);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign empty   = (r_count == '0);

    // Decode the operation into a cell command, status and next count
    always_comb begin
        cell_ctl      = '0;
        cell_ctl.load = accept;
        cell_idx      = '0;
        status        = ST_OK;
        n_count       = r_count;
        unique case (t_opcode'(i_opcode))
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                if (full) begin
                    status = ST_FULL;
                end else if (t_opcode'(i_opcode) == OP_INS_FIRST) begin
                    cell_ctl.ins = 1'b1;
                end else if (t_opcode'(i_opcode) == OP_INS_LAST) begin
                    cell_ctl.ins = 1'b1;
                    cell_idx     = r_count[IDX_W-1:0];
                end else if (!pos_ok) begin
                    status = ST_BAD;
                end else begin
                    cell_ctl.ins = 1'b1;
                    cell_idx     = pos_m1[IDX_W-1:0];
                end
                if (cell_ctl.ins) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (t_opcode'(i_opcode) == OP_DEL_FIRST) begin
                    cell_ctl.del = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                end else if (t_opcode'(i_opcode) == OP_DEL_LAST) begin
                    n_count = r_count - CNT_W'(1);
                end else if (!pos_ok) begin
                    status = ST_BAD;
                end else begin
                    cell_ctl.del = 1'b1;
                    cell_idx     = pos_m1[IDX_W-1:0];
                    n_count      = r_count - CNT_W'(1);
                end
            end
            OP_READ_AT: begin
                if (!pos_ok) begin
                    status = ST_BAD;
                end else begin
                    cell_ctl.rd = 1'b1;
                    cell_idx    = pos_m1[IDX_W-1:0];
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // Chain of slot cells, each wired to its neighbours
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] left_d;
        logic signed [VALUE_W-1:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = i_value;
        end else begin : g_mid_l
            assign left_d = slot_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_d = slot_q[g];
        end else begin : g_mid_r
            assign right_d = slot_q[g+1];
        end
        pal_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_idx   (cell_idx),
            .i_value (i_value),
            .i_left  (left_d),
            .i_right (right_d),
            .o_slot  (slot_q[g]),
            .o_tap   (tap_q[g])
        );
    end

    // Combine the read taps; at most one is non-zero
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            tap_or = tap_or | tap_q[k];
        end
    end

    // Control state
    always_comb begin
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        if (move) begin
            n_pend = 1'b0;
        end
        if (accept) begin
            n_pend = 1'b1;
        end
        if (move) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Payload: decode stage, then output register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_status <= status;
            r_p_count  <= n_count;
        end
        if (move) begin
            r_status     <= r_p_status;
            r_o_count    <= r_p_count;
            r_read_value <= tap_or;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;
    assign o_count      = r_o_count;

endmodule

@@ sv/pal_cell.sv @@
// One slot of the list chain: holds a value, shifts from either neighbour.
// Depends on pal_pkg.
module pal_cell import pal_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    parameter int unsigned IDX      = 0,
    localparam int unsigned IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic signed [VALUE_W-1:0] i_left,
    input  logic signed [VALUE_W-1:0] i_right,
    output logic signed [VALUE_W-1:0] o_slot,
    output logic signed [VALUE_W-1:0] o_tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [VALUE_W-1:0] r_slot;
    logic signed [VALUE_W-1:0] r_tap;
    logic signed [VALUE_W-1:0] n_slot;
    logic signed [VALUE_W-1:0] n_tap;

    // Pick the new value, a neighbour, or hold
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.load && i_ctl.ins) begin
            if (MY_IDX == i_idx) begin
                n_slot = i_value;
            end else if (MY_IDX > i_idx) begin
                n_slot = i_left;
            end
        end else if (i_ctl.load && i_ctl.del) begin
            if (MY_IDX >= i_idx) begin
                n_slot = i_right;
            end
        end
    end

    // Read tap: this slot's value when selected, zero on any other accepted transaction; held while none is accepted
    always_comb begin
        n_tap = r_tap;
        if (i_ctl.load) begin
            n_tap = (i_ctl.rd && (MY_IDX == i_idx)) ? r_slot : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_tap  <= n_tap;
    end

    assign o_slot = r_slot;
    assign o_tap  = r_tap;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for positional_array_list_top.
// Holds its own list predictor and a queue of expected results; needs pal_pkg
// and the RTL of the block, nothing else.
module tb;
    import pal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH     = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 8;

    typedef struct {
        t_status            status;
        logic signed [31:0] read_value;
        logic [6:0]         count;
    } t_list_result;

    // DUT ports
    logic                       i_clk;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic                       o_stall;
    logic [OPCODE_W-1:0]        i_opcode     = OP_NONE;
    logic [POS_W-1:0]           i_position   = '0;
    logic signed [VALUE_W-1:0]  i_value      = '0;
    logic                       o_valid;
    logic                       i_stall      = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic signed [VALUE_W-1:0]  o_read_value;
    logic [COUNT_W-1:0]         o_count;

    // Predicted list contents and the results still owed by the block
    logic signed [31:0] list_shadow [LIST_DEPTH];
    int                 list_fill = 0;
    t_list_result       expected_results [$];
    t_list_result       oldest_result;

    int fail_count    = 0;
    int idle_cycles   = 0;
    int stall_left    = 0;
    bit quiet         = 1'b0;
    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;

    positional_array_list_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow list and return the result it owes
    function automatic t_list_result apply_list_op(t_opcode op, int pos,
                                                   logic signed [31:0] val);
        t_list_result r;
        bit           pos_ok;
        int           idx;
        r.status     = ST_OK;
        r.read_value = '0;
        pos_ok       = (pos >= 1) && (pos <= list_fill);
        case (op)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                if (list_fill >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (op == OP_INS_AT && !pos_ok) begin
                    r.status = ST_BAD;
                end else begin
                    idx = (op == OP_INS_FIRST) ? 0 :
                          (op == OP_INS_LAST)  ? list_fill : pos - 1;
                    for (int i = list_fill; i > idx; i--)
                        list_shadow[i] = list_shadow[i-1];
                    list_shadow[idx] = val;
                    list_fill++;
                end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
                if (list_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (op == OP_DEL_AT && !pos_ok) begin
                    r.status = ST_BAD;
                end else begin
                    idx = (op == OP_DEL_FIRST) ? 0 :
                          (op == OP_DEL_LAST)  ? list_fill - 1 : pos - 1;
                    for (int i = idx; i < list_fill - 1; i++)
                        list_shadow[i] = list_shadow[i+1];
                    list_fill--;
                end
            end
            OP_READ_AT: begin
                if (!pos_ok)
                    r.status = ST_BAD;
                else
                    r.read_value = list_shadow[pos-1];
            end
            default: ;
        endcase
        r.count = list_fill[6:0];
        return r;
    endfunction

    // Random element value, weighted towards the extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly an in-range position, sometimes one just outside or anywhere
    function automatic int pick_position();
        if (list_fill > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(1, list_fill);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return (list_fill < LIST_DEPTH) ? list_fill + 1 : 0;
            default: return $urandom_range(0, LIST_DEPTH);
        endcase
    endfunction

    // Present one transaction, wait for it to be taken, then maybe leave a gap
    task automatic issue_op(t_opcode op, int pos, logic signed [31:0] val);
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_position <= pos[POS_W-1:0];
        i_value    <= val;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(apply_list_op(op, pos, val));
        if ($urandom_range(0, 31) == 0)
            sender_gaps = !sender_gaps;
        if (!quiet && sender_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // One random operation; grow_pct sets how often a change is an insert
    task automatic random_op(int grow_pct);
        int           r;
        t_opcode      op;
        r = $urandom_range(0, 99);
        if (r < 1)
            op = OP_NONE;
        else if (r < 20)
            op = OP_READ_AT;
        else if ($urandom_range(0, 99) < grow_pct)
            op = t_opcode'($urandom_range(OP_INS_FIRST, OP_INS_AT));
        else
            op = t_opcode'($urandom_range(OP_DEL_FIRST, OP_DEL_AT));
        if (op == OP_INS_AT || op == OP_DEL_AT || op == OP_READ_AT)
            issue_op(op, pick_position(), pick_value());
        else
            issue_op(op, $urandom_range(0, LIST_DEPTH), pick_value());
    endtask

    // Every rejection an empty list can give, plus the unused opcode
    task automatic test_empty_list();
        issue_op(OP_DEL_FIRST, 0, 32'sd5);
        issue_op(OP_DEL_LAST,  1, 32'sd5);
        issue_op(OP_DEL_AT,    1, 32'sd5);
        issue_op(OP_INS_AT,    1, 32'sd5);
        issue_op(OP_READ_AT,   1, 32'sd0);
        issue_op(OP_READ_AT,   0, 32'sd0);
        issue_op(OP_NONE,      3, 32'sd9);
    endtask

    // Each operation on a short list, with value extremes and edge positions
    task automatic test_basic_ops();
        issue_op(OP_INS_FIRST, 0, 32'sh8000_0000);
        issue_op(OP_INS_LAST,  0, 32'sh7FFF_FFFF);
        issue_op(OP_INS_AT,    2, 32'sd0);
        issue_op(OP_INS_AT,    1, -32'sd1);
        for (int p = 0; p <= 5; p++)
            issue_op(OP_READ_AT, p, 32'sd0);
        issue_op(OP_INS_AT,    5, 32'sd7);
        issue_op(OP_DEL_AT,    5, 32'sd0);
        issue_op(OP_DEL_AT,    0, 32'sd0);
        issue_op(OP_DEL_AT,    2, 32'sd0);
        issue_op(OP_DEL_FIRST, 0, 32'sd0);
        issue_op(OP_DEL_LAST,  0, 32'sd0);
        issue_op(OP_NONE,      1, 32'sd0);
        issue_op(OP_READ_AT,   1, 32'sd0);
    endtask

    // Fill the whole capacity, then work at the full boundary
    task automatic test_full_list();
        while (list_fill < LIST_DEPTH)
            issue_op(OP_INS_LAST, $urandom_range(0, LIST_DEPTH), pick_value());
        issue_op(OP_INS_FIRST, 0, 32'sd1);
        issue_op(OP_INS_LAST,  0, 32'sd1);
        issue_op(OP_INS_AT,    1, 32'sd1);
        issue_op(OP_INS_AT,    0, 32'sd1);
        issue_op(OP_READ_AT,   LIST_DEPTH, 32'sd0);
        issue_op(OP_READ_AT,   1, 32'sd0);
        issue_op(OP_DEL_AT,    LIST_DEPTH, 32'sd0);
        issue_op(OP_READ_AT,   LIST_DEPTH, 32'sd0);
        issue_op(OP_INS_AT,    LIST_DEPTH - 1, pick_value());
        issue_op(OP_READ_AT,   LIST_DEPTH, 32'sd0);
        issue_op(OP_DEL_FIRST, 0, 32'sd0);
        issue_op(OP_INS_FIRST, 0, pick_value());
    endtask

    // Random walk that swings the count between empty and full
    task automatic test_random_walk(int n_items);
        bit growing;
        growing = 1'b0;
        for (int n = 0; n < n_items; n++) begin
            if (list_fill == LIST_DEPTH)
                growing = 1'b0;
            else if (list_fill == 0)
                growing = 1'b1;
            random_op(growing ? 75 : 25);
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_back_to_back(int n_items);
        @(posedge i_clk);
        quiet = 1'b1;
        for (int n = 0; n < n_items; n++)
            random_op(50);
    endtask

    // Result sink: random stall bursts, switched on and off in stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0)
            receiver_gaps = !receiver_gaps;
        if (stall_left > 0)
            stall_left--;
        else if (!quiet && receiver_gaps && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 9);
        i_stall <= (stall_left > 0) && !quiet;
    end

    // Compare each taken result with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d, read_value %0d, count %0d",
                       o_status, o_read_value, o_count);
                fail_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_status !== oldest_result.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           oldest_result.status, o_status);
                    fail_count++;
                end
                if (o_read_value !== oldest_result.read_value) begin
                    $error("read_value mismatch: expected %0d, actual %0d",
                           oldest_result.read_value, o_read_value);
                    fail_count++;
                end
                if (o_count !== oldest_result.count) begin
                    $error("count mismatch: expected %0d, actual %0d",
                           oldest_result.count, o_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("** positional_array_list_top: FAILED **");
            $finish;
        end
    end

    // Test sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_ops();
        drain_results();
        test_full_list();
        drain_results();
        test_random_walk(340);
        drain_results();
        test_back_to_back(60);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("** positional_array_list_top: PASSED **");
        else
            $display("** positional_array_list_top: FAILED **");
        $finish;
    end

endmodule
